>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AST_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/psae_pkg.sv
// Package of the pillar scatter address engine: constants, codes and types.
package psae_pkg;

  // Defaults of the top-level sizing parameters
  localparam int MAX_BATCH_DEF  = 4;
  localparam int MAX_GRID_X_DEF = 512;
  localparam int MAX_GRID_Y_DEF = 512;

  // Fixed limits
  localparam int MAX_CHANNELS = 64;
  localparam int MAX_PILLARS  = 32768;
  localparam int PLACE_CAP    = (MAX_PILLARS > 65535) ? 65535 : MAX_PILLARS;

  // Occupancy bitmap word
  localparam int MAP_WORD  = 64;
  localparam int MAP_BIT_W = $clog2(MAP_WORD);

  // Multiply-add unit widths
  localparam int ACC_W = 26;
  localparam int OPB_W = 10;

  // Port widths
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Input commands
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_SCATTER = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH    = 2'd3;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NEG_BATCH = 3'd1,
    ST_OUTSIDE   = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_BATCH_CAP = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_CHECK,
    S_MUL_T1,
    S_MUL_CELL,
    S_MUL_PLANE,
    S_MUL_SRC,
    S_MUL_T2,
    S_MUL_T3,
    S_MUL_DST,
    S_PREP,
    S_EMIT,
    S_START,
    S_ERR
  } state_t;

  // One request to the multiply-add unit: acc = a * b + c, low ACC_W bits
  typedef struct packed {
    logic             en;
    logic [ACC_W-1:0] a;
    logic [OPB_W-1:0] b;
    logic [ACC_W-1:0] c;
  } mul_req_t;

endpackage

>>> rtl/core/psae_muladd.sv
// Shared multiply-add unit with a registered result.
module psae_muladd (
  input  logic                             clk,
  input  psae_pkg::mul_req_t               req,
  output logic [psae_pkg::ACC_W-1:0]       acc_r
);

  localparam int PROD_W = psae_pkg::ACC_W + psae_pkg::OPB_W;

  logic [PROD_W-1:0]          prod;
  logic [psae_pkg::ACC_W-1:0] acc_nxt;

  // Product kept modulo 2^ACC_W, then the addend
  assign prod    = PROD_W'(req.a) * PROD_W'(req.b);
  assign acc_nxt = prod[psae_pkg::ACC_W-1:0] + req.c;

  always_ff @(posedge clk) begin
    if (req.en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

>>> rtl/core/psae_bitmap.sv
// Occupancy bitmap RAM: one write port, one registered read port.
module psae_bitmap #(
  parameter int ROWS = 1,
  parameter int WORD = 1,
  parameter int AW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic            clk,
  input  logic [AW-1:0]   rd_addr,
  output logic [WORD-1:0] rd_data_r,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [WORD-1:0] wr_data
);

  logic [WORD-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

>>> rtl/core/pillar_scatter_address_engine_top.sv
// Pillar scatter address engine: checks pillars and issues per-channel copy commands.
// Each scatter beat is range checked, looked up in a per-batch occupancy bitmap and, if
// accepted, turned into one copy command per effective channel, one per cycle while
// out_tready is high. For a placed pillar, seven products run in series through the one
// shared multiply-add unit (cell index, plane size, source base, destination base), then
// the output register paces the commands. A rejected pillar goes to its status result
// after the range check, or after the bitmap lookup for a duplicate cell.
// A start-frame beat yields its result and then clears the bitmap one 64-bit row a
// cycle, all MAX_BATCH*MAX_GRID_X*MAX_GRID_Y/64 rows (16384 at the defaults); the same
// clearing pass runs after reset. in_tready is low during any of this work; the next
// beat is taken while the last result still waits in the output register.
module pillar_scatter_address_engine_top #(
  parameter int MAX_BATCH  = psae_pkg::MAX_BATCH_DEF,
  parameter int MAX_GRID_X = psae_pkg::MAX_GRID_X_DEF,
  parameter int MAX_GRID_Y = psae_pkg::MAX_GRID_Y_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pillar_index[14:0], batch_coord[30:15], z_coord[46:31], y_coord[62:47],
  // x_coord[78:63], zero[79]
  input  logic [psae_pkg::IN_DATA_W-1:0]      in_tdata,
  // command[0]
  input  logic                                in_tuser,
  // Result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // source_index[20:0], dest_index[46:21], channel_number[52:47],
  // batch_total[55:53], pillars_placed[71:56]
  output logic [psae_pkg::OUT_DATA_W-1:0]     out_tdata,
  // write_valid[0], status[3:1]
  output logic [psae_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                                out_tlast,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [psae_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psae_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int MAP_CELLS = MAX_BATCH * MAX_GRID_X * MAX_GRID_Y;
  localparam int MAP_ROWS  = (MAP_CELLS + psae_pkg::MAP_WORD - 1) / psae_pkg::MAP_WORD;
  localparam int ROW_AW    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int BCNT_W    = $clog2(MAX_BATCH + 1);
  localparam int ACC_W     = psae_pkg::ACC_W;
  localparam int OPB_W     = psae_pkg::OPB_W;
  localparam int WORD      = psae_pkg::MAP_WORD;

  // Sequencer
  psae_pkg::state_t  state_r, state_nxt;

  // Configuration registers
  logic [6:0]        channel_count_r;
  logic [9:0]        grid_width_r;
  logic [9:0]        grid_height_r;
  logic [14:0]       grid_depth_r;

  // Captured input beat
  logic [14:0]       pidx_r;
  logic [15:0]       batch_r, z_r, y_r, x_r;

  // Working registers
  psae_pkg::status_t err_status_r;
  logic [ACC_W-1:0]  cell_r, plane_r, dst_r;
  logic [20:0]       src_r;
  logic [5:0]        ch_idx_r;
  logic [BCNT_W-1:0] batch_count_r;
  logic [15:0]       placed_r;
  logic [ROW_AW-1:0] clr_addr_r;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_write_r;
  logic [20:0]       out_src_r;
  logic [ACC_W-1:0]  out_dst_r;
  logic [5:0]        out_ch_r;
  psae_pkg::status_t out_status_r;
  logic              out_last_r;
  logic [2:0]        out_bt_r;
  logic [15:0]       out_placed_r;

  // Shared unit and bitmap connections
  psae_pkg::mul_req_t mul_req;
  logic [ACC_W-1:0]  acc_r;
  logic [ROW_AW-1:0] map_rd_addr, map_wr_addr;
  logic [WORD-1:0]   map_rd_data_r, map_wr_data;
  logic              map_wr_en;

  // Decoded conditions
  logic [6:0]        ch_eff;
  logic [9:0]        gw_eff, gh_eff;
  logic              in_fire, slot_free, out_load;
  logic              neg_batch, over_batch, outside, dup, last_ch;

  // Effective grid and channel sizes
  always_comb begin
    if (channel_count_r == 7'd0) begin
      ch_eff = 7'd1;
    end else if (32'(channel_count_r) > psae_pkg::MAX_CHANNELS) begin
      ch_eff = 7'(psae_pkg::MAX_CHANNELS);
    end else begin
      ch_eff = channel_count_r;
    end
    gw_eff = (32'(grid_width_r) > MAX_GRID_X) ? 10'(MAX_GRID_X) : grid_width_r;
    gh_eff = (32'(grid_height_r) > MAX_GRID_Y) ? 10'(MAX_GRID_Y) : grid_height_r;
  end

  // Checks on the captured pillar
  assign neg_batch  = batch_r[15];
  assign over_batch = 32'(batch_r[14:0]) >= MAX_BATCH;
  assign outside    = z_r[15] || (z_r[14:0] >= grid_depth_r) ||
                      y_r[15] || (y_r[14:0] >= 15'(gh_eff)) ||
                      x_r[15] || (x_r[14:0] >= 15'(gw_eff));
  assign dup        = map_rd_data_r[cell_r[psae_pkg::MAP_BIT_W-1:0]];
  assign last_ch    = ({1'b0, ch_idx_r} + 7'd1) == ch_eff;

  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // Bitmap read follows the cell index as it leaves the multiply-add unit
  assign map_rd_addr = ROW_AW'(acc_r >> psae_pkg::MAP_BIT_W);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psae_pkg::S_CLR: begin
        if (clr_addr_r == ROW_AW'(MAP_ROWS - 1)) state_nxt = psae_pkg::S_IDLE;
      end
      psae_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_tuser == psae_pkg::CMD_START) ? psae_pkg::S_START
                                                        : psae_pkg::S_CHECK;
        end
      end
      psae_pkg::S_START: begin
        if (slot_free) state_nxt = psae_pkg::S_CLR;
      end
      psae_pkg::S_CHECK: begin
        state_nxt = (neg_batch || over_batch || outside) ? psae_pkg::S_ERR
                                                         : psae_pkg::S_MUL_T1;
      end
      psae_pkg::S_MUL_T1:    state_nxt = psae_pkg::S_MUL_CELL;
      psae_pkg::S_MUL_CELL:  state_nxt = psae_pkg::S_MUL_PLANE;
      psae_pkg::S_MUL_PLANE: state_nxt = psae_pkg::S_MUL_SRC;
      psae_pkg::S_MUL_SRC: begin
        state_nxt = dup ? psae_pkg::S_ERR : psae_pkg::S_MUL_T2;
      end
      psae_pkg::S_MUL_T2:    state_nxt = psae_pkg::S_MUL_T3;
      psae_pkg::S_MUL_T3:    state_nxt = psae_pkg::S_MUL_DST;
      psae_pkg::S_MUL_DST:   state_nxt = psae_pkg::S_PREP;
      psae_pkg::S_PREP:      state_nxt = psae_pkg::S_EMIT;
      psae_pkg::S_EMIT: begin
        if (slot_free && last_ch) state_nxt = psae_pkg::S_IDLE;
      end
      psae_pkg::S_ERR: begin
        if (slot_free) state_nxt = psae_pkg::S_IDLE;
      end
      default: state_nxt = psae_pkg::S_IDLE;
    endcase
  end

  // State outputs: operand selection, bitmap port, result load, ready
  always_comb begin
    mul_req     = '0;
    map_wr_en   = 1'b0;
    map_wr_addr = ROW_AW'(cell_r >> psae_pkg::MAP_BIT_W);
    map_wr_data = map_rd_data_r | (WORD'(1) << cell_r[psae_pkg::MAP_BIT_W-1:0]);
    out_load    = 1'b0;
    in_tready   = 1'b0;
    unique case (state_r)
      psae_pkg::S_CLR: begin
        map_wr_en   = 1'b1;
        map_wr_addr = clr_addr_r;
        map_wr_data = '0;
      end
      psae_pkg::S_IDLE: in_tready = 1'b1;
      // (b * h + y)
      psae_pkg::S_MUL_T1: begin
        mul_req = '{en: 1'b1, a: ACC_W'(batch_r[14:0]), b: gh_eff,
                    c: ACC_W'(y_r[14:0])};
      end
      // cell = (b * h + y) * w + x
      psae_pkg::S_MUL_CELL: begin
        mul_req = '{en: 1'b1, a: acc_r, b: gw_eff, c: ACC_W'(x_r[14:0])};
      end
      // plane = h * w, bitmap row read in flight
      psae_pkg::S_MUL_PLANE: begin
        mul_req = '{en: 1'b1, a: ACC_W'(gh_eff), b: gw_eff, c: '0};
      end
      // source base = pillar * channels; mark the cell unless taken
      psae_pkg::S_MUL_SRC: begin
        mul_req   = '{en: 1'b1, a: ACC_W'(pidx_r), b: OPB_W'(ch_eff), c: '0};
        map_wr_en = !dup;
      end
      psae_pkg::S_MUL_T2: begin
        mul_req = '{en: 1'b1, a: ACC_W'(batch_r[14:0]), b: OPB_W'(ch_eff), c: '0};
      end
      psae_pkg::S_MUL_T3: begin
        mul_req = '{en: 1'b1, a: acc_r, b: gh_eff, c: ACC_W'(y_r[14:0])};
      end
      psae_pkg::S_MUL_DST: begin
        mul_req = '{en: 1'b1, a: acc_r, b: gw_eff, c: ACC_W'(x_r[14:0])};
      end
      psae_pkg::S_EMIT, psae_pkg::S_START, psae_pkg::S_ERR: out_load = slot_free;
      default: ;
    endcase
  end

  // Output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= psae_pkg::S_CLR;
      out_valid_r     <= 1'b0;
      clr_addr_r      <= '0;
      batch_count_r   <= BCNT_W'(1);
      placed_r        <= '0;
      channel_count_r <= 7'd64;
      grid_width_r    <= 10'd512;
      grid_height_r   <= 10'd512;
      grid_depth_r    <= 15'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;

      // Configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          psae_pkg::CFG_CHANNELS: channel_count_r <= cfg_wdata[6:0];
          psae_pkg::CFG_WIDTH:    grid_width_r    <= cfg_wdata[9:0];
          psae_pkg::CFG_HEIGHT:   grid_height_r   <= cfg_wdata[9:0];
          psae_pkg::CFG_DEPTH:    grid_depth_r    <= cfg_wdata;
        endcase
      end

      // Clearing sweep address
      if (state_r == psae_pkg::S_START) begin
        clr_addr_r <= '0;
      end else if (state_r == psae_pkg::S_CLR) begin
        clr_addr_r <= clr_addr_r + ROW_AW'(1);
      end

      // Frame counters
      if (state_r == psae_pkg::S_START && slot_free) begin
        batch_count_r <= BCNT_W'(1);
        placed_r      <= '0;
      end else if (state_r == psae_pkg::S_MUL_SRC && !dup) begin
        if (BCNT_W'(batch_r[14:0]) + BCNT_W'(1) > batch_count_r) begin
          batch_count_r <= BCNT_W'(batch_r[14:0]) + BCNT_W'(1);
        end
        if (32'(placed_r) < psae_pkg::PLACE_CAP) begin
          placed_r <= placed_r + 16'd1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pidx_r  <= in_tdata[14:0];
      batch_r <= in_tdata[30:15];
      z_r     <= in_tdata[46:31];
      y_r     <= in_tdata[62:47];
      x_r     <= in_tdata[78:63];
    end

    // Error code, first failing check wins
    if (state_r == psae_pkg::S_CHECK) begin
      if (neg_batch)       err_status_r <= psae_pkg::ST_NEG_BATCH;
      else if (over_batch) err_status_r <= psae_pkg::ST_BATCH_CAP;
      else                 err_status_r <= psae_pkg::ST_OUTSIDE;
    end

    // Capture products as they come out of the shared unit
    if (state_r == psae_pkg::S_MUL_PLANE) cell_r <= acc_r;
    if (state_r == psae_pkg::S_MUL_SRC) begin
      plane_r <= acc_r;
      if (dup) err_status_r <= psae_pkg::ST_DUPLICATE;
    end
    if (state_r == psae_pkg::S_MUL_T2) src_r <= acc_r[20:0];
    if (state_r == psae_pkg::S_PREP) begin
      dst_r    <= acc_r;
      ch_idx_r <= '0;
    end

    // Step to the next channel: source +1, destination +1 plane
    if (state_r == psae_pkg::S_EMIT && out_load) begin
      src_r    <= src_r + 21'd1;
      dst_r    <= dst_r + plane_r;
      ch_idx_r <= ch_idx_r + 6'd1;
    end

    // Result register load
    if (out_load) begin
      unique case (state_r)
        psae_pkg::S_EMIT: begin
          out_write_r  <= 1'b1;
          out_src_r    <= src_r;
          out_dst_r    <= dst_r;
          out_ch_r     <= ch_idx_r;
          out_status_r <= psae_pkg::ST_OK;
          out_last_r   <= last_ch;
          out_bt_r     <= 3'(batch_count_r);
          out_placed_r <= placed_r;
        end
        psae_pkg::S_START: begin
          out_write_r  <= 1'b0;
          out_src_r    <= '0;
          out_dst_r    <= '0;
          out_ch_r     <= '0;
          out_status_r <= psae_pkg::ST_OK;
          out_last_r   <= 1'b1;
          out_bt_r     <= 3'd1;
          out_placed_r <= '0;
        end
        default: begin
          out_write_r  <= 1'b0;
          out_src_r    <= '0;
          out_dst_r    <= '0;
          out_ch_r     <= '0;
          out_status_r <= err_status_r;
          out_last_r   <= 1'b1;
          out_bt_r     <= 3'(batch_count_r);
          out_placed_r <= placed_r;
        end
      endcase
    end
  end

  // Result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_placed_r, out_bt_r, out_ch_r, out_dst_r, out_src_r};
  assign out_tuser  = {out_status_r, out_write_r};
  assign out_tlast  = out_last_r;

  psae_muladd u_muladd (
    .clk   (clk),
    .req   (mul_req),
    .acc_r (acc_r)
  );

  psae_bitmap #(
    .ROWS (MAP_ROWS),
    .WORD (WORD),
    .AW   (ROW_AW)
  ) u_bitmap (
    .clk       (clk),
    .rd_addr   (map_rd_addr),
    .rd_data_r (map_rd_data_r),
    .wr_en     (map_wr_en),
    .wr_addr   (map_wr_addr),
    .wr_data   (map_wr_data)
  );

endmodule

>>> rtl/core/psae_checker.sv
// Port-level checker of the pillar scatter address engine, bound to the top level.
`include "assert_macros.svh"

module psae_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [psae_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic [psae_pkg::OUT_USER_W-1:0]   out_tuser,
  input logic                              out_tlast
);

  // A stalled result beat holds
  `AST_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Status and start results close their run
  `AST_IMPLY(a_nocopy_last, out_tvalid && !out_tuser[0], out_tlast)

  // Status and start results carry no addresses
  `AST_IMPLY(a_nocopy_zero, out_tvalid && !out_tuser[0], out_tdata[52:0] == 53'd0)

  // Copy commands always report status ok
  `AST_IMPLY(a_copy_ok, out_tvalid && out_tuser[0], out_tuser[3:1] == 3'd0)

  // A start-frame beat is followed by the clearing pass
  `AST_NEXT(a_start_busy, in_tvalid && in_tready && (in_tuser == psae_pkg::CMD_START),
            !in_tready)

endmodule

bind pillar_scatter_address_engine_top psae_checker u_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for the pillar scatter address engine: stimulus, prediction, checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psae_pkg::*;

  localparam int BATCH_LIMIT  = MAX_BATCH_DEF;
  localparam int GRID_X_LIMIT = MAX_GRID_X_DEF;
  localparam int GRID_Y_LIMIT = MAX_GRID_Y_DEF;

  // Run sizing. Slowest legal run: ~475 pillars at 64 copies, each copy stalled by the
  // longest drawn wait, plus up to 15 bitmap clears; the limit covers that.
  localparam int ITEM_TARGET = 470;
  localparam int START_CAP   = 14;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_TAIL  = 100;

  // Idle patterns for sender and receiver
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_FULL   = 1;
  localparam int IDLE_SPARSE = 2;

  typedef struct {
    logic        cmd;
    logic [14:0] pidx;
    logic [15:0] b;
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
  } pillar_beat_t;

  typedef struct {
    logic        wv;
    logic [20:0] src;
    logic [25:0] dst;
    logic [5:0]  chn;
    status_t     st;
    logic        last;
    logic [2:0]  btot;
    logic [15:0] placed;
  } copy_cmd_t;

  typedef struct {
    int b;
    int z;
    int y;
    int x;
  } cell_pos_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = CMD_START;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_CHANNELS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pillar_scatter_address_engine_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Register mirror, loaded with the reset values
  logic [6:0]  reg_channels = 7'd64;
  logic [9:0]  reg_width    = 10'd512;
  logic [9:0]  reg_height   = 10'd512;
  logic [14:0] reg_depth    = 15'd1;

  // Model state: occupied cells of the current frame and the two counters
  bit          occupied [int unsigned];
  logic [2:0]  batch_total = 3'd1;
  logic [15:0] pillars_placed = 16'd0;

  pillar_beat_t pillar_backlog [$];
  copy_cmd_t    copy_cmd_due [$];
  cell_pos_t    recent_cells [$];

  int send_mode = IDLE_NONE;
  int recv_mode = IDLE_NONE;
  int send_gap = 0;
  int recv_hold = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  int cycle_count = 0;
  int mismatches = 0;
  int n_queued = 0;
  int n_starts_queued = 0;
  int n_in_beats = 0;
  int n_out_beats = 0;
  int n_starts = 0;
  int n_placed = 0;
  int n_rejected = 0;
  int n_settings = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d result beats still due",
               cycle_count, copy_cmd_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int draw_wait(int pattern);
    case (pattern)
      IDLE_FULL:   return $urandom_range(0, 18);
      IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      default:     return 0;
    endcase
  endfunction

  // Effective sizes as the engine sees them
  function automatic int eff_channels();
    if (reg_channels == 0) return 1;
    if (reg_channels > MAX_CHANNELS) return MAX_CHANNELS;
    return reg_channels;
  endfunction

  function automatic int eff_dim(logic [9:0] v, int cap);
    return (v > cap) ? cap : v;
  endfunction

  function automatic void due_beat(logic wv, int src, longint unsigned dst, int chn,
                                   status_t st, logic last);
    copy_cmd_t cmd;
    cmd.wv     = wv;
    cmd.src    = 21'(src);
    cmd.dst    = 26'(dst);
    cmd.chn    = 6'(chn);
    cmd.st     = st;
    cmd.last   = last;
    cmd.btot   = batch_total;
    cmd.placed = pillars_placed;
    copy_cmd_due.push_back(cmd);
  endfunction

  // Predict the copy commands (or the single status beat) that one input beat causes
  function automatic void scatter_pillar(pillar_beat_t beat);
    int ch, gw, gh, gd, b, z, y, x;
    int unsigned cell_id;
    longint unsigned dst;
    status_t st;
    if (beat.cmd == CMD_START) begin
      occupied.delete();
      batch_total    = 3'd1;
      pillars_placed = 16'd0;
      n_starts++;
      due_beat(1'b0, 0, 0, 0, ST_OK, 1'b1);
      return;
    end
    ch = eff_channels();
    gw = eff_dim(reg_width, GRID_X_LIMIT);
    gh = eff_dim(reg_height, GRID_Y_LIMIT);
    gd = reg_depth;
    b  = int'($signed(beat.b));
    z  = int'($signed(beat.z));
    y  = int'($signed(beat.y));
    x  = int'($signed(beat.x));
    cell_id = 0;
    // checks in priority order
    if (b < 0) st = ST_NEG_BATCH;
    else if (b >= BATCH_LIMIT) st = ST_BATCH_CAP;
    else if (z < 0 || z >= gd || y < 0 || y >= gh || x < 0 || x >= gw) st = ST_OUTSIDE;
    else begin
      cell_id = (b * gh + y) * gw + x;
      st = occupied.exists(cell_id) ? ST_DUPLICATE : ST_OK;
    end
    if (st != ST_OK) begin
      n_rejected++;
      due_beat(1'b0, 0, 0, 0, st, 1'b1);
      return;
    end
    occupied[cell_id] = 1'b1;
    if (b + 1 > batch_total) batch_total = 3'(b + 1);
    if (pillars_placed < PLACE_CAP) pillars_placed++;
    n_placed++;
    for (int c = 0; c < ch; c++) begin
      dst = ((longint'(b) * ch + c) * gh + y) * gw + x;
      due_beat(1'b1, beat.pidx * ch + c, dst, c, ST_OK, c == ch - 1);
    end
  endfunction

  function automatic void check_field(string name, logic [25:0] due_val, logic [25:0] got);
    if (got !== due_val) begin
      $error("%s: expected %0d, got %0d", name, due_val, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_copy_cmd();
    copy_cmd_t due;
    if (copy_cmd_due.size() == 0) begin
      $error("result beat with nothing due: tdata %h tuser %h", out_tdata, out_tuser);
      mismatches++;
      return;
    end
    due = copy_cmd_due.pop_front();
    check_field("write_valid",    due.wv,     out_tuser[0]);
    check_field("status",         due.st,     out_tuser[3:1]);
    check_field("source_index",   due.src,    out_tdata[20:0]);
    check_field("dest_index",     due.dst,    out_tdata[46:21]);
    check_field("channel_number", due.chn,    out_tdata[52:47]);
    check_field("batch_total",    due.btot,   out_tdata[55:53]);
    check_field("pillars_placed", due.placed, out_tdata[71:56]);
    check_field("last_of_run",    due.last,   out_tlast);
  endfunction

  // Beat monitor: check result beats first, then predict for an accepted input beat
  always @(posedge clk) begin : beat_monitor
    pillar_beat_t beat;
    in_taken  <= rst_n && in_tvalid && in_tready;
    out_taken <= rst_n && out_tvalid && out_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_out_beats++;
        compare_copy_cmd();
      end
      if (in_tvalid && in_tready) begin
        beat.cmd  = in_tuser;
        beat.pidx = in_tdata[14:0];
        beat.b    = in_tdata[30:15];
        beat.z    = in_tdata[46:31];
        beat.y    = in_tdata[62:47];
        beat.x    = in_tdata[78:63];
        n_in_beats++;
        scatter_pillar(beat);
      end
    end
  end

  // Input driver: holds a beat until taken, then waits its drawn gap
  always @(negedge clk) begin : pillar_driver
    pillar_beat_t beat;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // beat still waiting for in_tready
    end else if (send_gap > 0) begin
      in_tvalid <= 1'b0;
      send_gap--;
    end else if (pillar_backlog.size() != 0) begin
      beat = pillar_backlog.pop_front();
      in_tdata  <= {1'b0, beat.x, beat.y, beat.z, beat.b, beat.pidx};
      in_tuser  <= beat.cmd;
      in_tvalid <= 1'b1;
      send_gap  = draw_wait(send_mode);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result sink: after each taken beat, stall for a drawn number of cycles
  always @(negedge clk) begin : result_sink
    int w;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (recv_hold > 0) begin
      out_tready <= 1'b0;
      recv_hold--;
    end else if (out_taken) begin
      w = draw_wait(recv_mode);
      if (w > 0) begin
        out_tready <= 1'b0;
        recv_hold = w - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void queue_pillar(int pidx, int b, int z, int y, int x);
    pillar_beat_t beat;
    beat.cmd  = CMD_SCATTER;
    beat.pidx = 15'(pidx);
    beat.b    = 16'(b);
    beat.z    = 16'(z);
    beat.y    = 16'(y);
    beat.x    = 16'(x);
    pillar_backlog.push_back(beat);
    n_queued++;
  endfunction

  function automatic void queue_start();
    pillar_beat_t beat;
    beat.cmd  = CMD_START;
    beat.pidx = '0;
    beat.b    = '0;
    beat.z    = '0;
    beat.y    = '0;
    beat.x    = '0;
    pillar_backlog.push_back(beat);
    n_queued++;
    n_starts_queued++;
    recent_cells.delete();
  endfunction

  // Mostly in-grid pillars, some reused cells and start frames, the rest noise and boundary values
  function automatic void queue_random_item();
    int r, gw, gh, gd, b, z, y, x;
    cell_pos_t pos;
    gw = eff_dim(reg_width, GRID_X_LIMIT);
    gh = eff_dim(reg_height, GRID_Y_LIMIT);
    gd = reg_depth;
    r  = $urandom_range(0, 99);
    b  = $urandom_range(0, BATCH_LIMIT - 1);
    z  = (gd > 0) ? $urandom_range(0, gd - 1) : $urandom_range(0, 3);
    y  = (gh > 0) ? $urandom_range(0, gh - 1) : $urandom_range(0, 3);
    x  = (gw > 0) ? $urandom_range(0, gw - 1) : $urandom_range(0, 3);
    if (r < 2 && n_starts_queued < START_CAP) begin
      queue_start();
      return;
    end
    if (r < 22 && recent_cells.size() != 0) begin
      pos = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
      b = pos.b;
      z = pos.z;
      y = pos.y;
      x = pos.x;
    end else if (r >= 75) begin
      case ($urandom_range(0, 5))
        0: begin
          b = $urandom_range(0, 65535);
          z = $urandom_range(0, 65535);
          y = $urandom_range(0, 65535);
          x = $urandom_range(0, 65535);
        end
        1: b = $urandom_range(32768, 65535);
        2: b = $urandom_range(BATCH_LIMIT, 32767);
        3: z = ($urandom_range(0, 1) == 0) ? -1 : gd;
        4: y = ($urandom_range(0, 1) == 0) ? -1 : gh;
        default: x = ($urandom_range(0, 1) == 0) ? -1 : gw;
      endcase
    end else if (recent_cells.size() < 64) begin
      pos.b = b;
      pos.z = z;
      pos.y = y;
      pos.x = x;
      recent_cells.push_back(pos);
    end
    queue_pillar($urandom_range(0, 32767), b, z, y, x);
  endfunction

  function automatic int pick_channels();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return 64;
      3: return $urandom_range(65, 127);
      4: return 2;
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic int pick_side();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 1;
      2, 3: return 512;
      4: return $urandom_range(513, 1023);
      5, 6, 7, 8, 9: return $urandom_range(1, 8);
      default: return $urandom_range(1, 512);
    endcase
  endfunction

  function automatic int pick_depth();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 32767;
      2, 3, 4: return $urandom_range(2, 32766);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  function automatic void shuffle_idling();
    send_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
    recv_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
  endfunction

  // Sender holds off until every queued beat is taken and every result has come
  task automatic wait_idle();
    while (pillar_backlog.size() != 0) @(negedge clk);
    @(posedge clk);
    do @(negedge clk); while (in_tvalid || copy_cmd_due.size() != 0);
  endtask

  // One write per cycle, all four registers; entered at a falling edge
  task automatic write_regs(int ch, int gw, int gh, int gd);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CHANNELS;
    cfg_wdata <= 15'(ch);
    reg_channels = 7'(ch);
    @(negedge clk);
    cfg_index <= CFG_WIDTH;
    cfg_wdata <= 15'(gw);
    reg_width = 10'(gw);
    @(negedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_wdata <= 15'(gh);
    reg_height = 10'(gh);
    @(negedge clk);
    cfg_index <= CFG_DEPTH;
    cfg_wdata <= 15'(gd);
    reg_depth = 15'(gd);
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin : stimulus
    int n_items;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset register values: every status, counter growth, extreme fields
    shuffle_idling();
    queue_start();
    queue_pillar(0, 0, 0, 0, 0);
    queue_pillar(1234, 1, 0, 7, 9);
    queue_pillar(32767, 3, 0, 511, 511);
    queue_pillar(5, 0, 0, 0, 0);
    queue_pillar(6, -1, 0, 0, 0);
    queue_pillar(7, -32768, 0, 0, 0);
    queue_pillar(8, 4, 0, 0, 0);
    queue_pillar(9, 32767, 0, 0, 0);
    queue_pillar(10, 0, 1, 0, 0);
    queue_pillar(11, 0, 0, 512, 0);
    queue_pillar(12, 0, 0, -1, 0);
    queue_pillar(13, 0, 0, 0, 512);
    queue_pillar(14, 0, 0, 0, -32768);
    // batch checks take priority over the range check
    queue_pillar(15, -1, 0, 0, 600);
    queue_pillar(16, 4, 0, -5, 0);

    // Zero grid sizes put every pillar outside
    wait_idle();
    write_regs(1, 0, 512, 1);
    queue_pillar(20, 0, 0, 0, 0);
    wait_idle();
    write_regs(1, 512, 0, 1);
    queue_pillar(21, 1, 0, 3, 3);
    wait_idle();
    write_regs(1, 512, 512, 0);
    queue_pillar(22, 0, 0, 1, 1);

    // Oversized grid saturates, channel count above the maximum acts as the maximum
    wait_idle();
    shuffle_idling();
    write_regs(127, 1023, 1023, 32767);
    queue_pillar(23, 2, 32766, 511, 511);
    queue_pillar(24, 0, 0, 0, 512);
    queue_pillar(25, 0, 32767, 0, 0);

    // Geometry change inside a frame, zero channel count acting as one
    wait_idle();
    write_regs(0, 1, 1, 1);
    queue_pillar(26, 0, 0, 0, 0);
    queue_pillar(27, 1, 0, 0, 0);
    queue_start();
    queue_pillar(28, 1, 0, 0, 0);

    // Random phases, each with its own register setting and idle pattern
    while (n_queued < ITEM_TARGET) begin
      wait_idle();
      write_regs(pick_channels(), pick_side(), pick_side(), pick_depth());
      shuffle_idling();
      recent_cells.delete();
      if ($urandom_range(0, 1) == 0 && n_starts_queued < START_CAP) queue_start();
      n_items = (eff_channels() > 32) ? $urandom_range(12, 30) : $urandom_range(25, 50);
      repeat (n_items) queue_random_item();
    end

    wait_idle();
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("Covered %0d input beats: %0d start frames, %0d pillars placed, %0d rejected.",
             n_in_beats, n_starts, n_placed, n_rejected);
    $display("Checked %0d result beats over %0d register settings, %0d field mismatches.",
             n_out_beats, n_settings + 1, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
